>>> rtl/core/uts_pkg.sv
`default_nettype none

package uts_pkg;

    // Field widths.
    localparam int CFG_W     = 12;
    localparam int BYTE_W    = 8;
    localparam int CHAR_W    = 7;
    localparam int CP_W      = 21;
    localparam int RES_MAX   = 4;
    localparam int RES_CNT_W = 3;
    localparam int RES_IDX_W = 2;
    localparam int EV_NUM    = 4;

    localparam logic [CFG_W-1:0] MAX_CHARS_RESET = 12'd127;

    // ASCII characters used by the transliteration.
    localparam logic [CHAR_W-1:0] CH_NUL   = 7'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 7'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 7'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 7'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CH_QUOTE = 7'h22;
    localparam logic [CHAR_W-1:0] CH_APOS  = 7'h27;
    localparam logic [CHAR_W-1:0] CH_DASH  = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT   = 7'h2E;
    localparam logic [CHAR_W-1:0] CH_DEL   = 7'h7F;
    localparam logic [CHAR_W-1:0] CH_A     = 7'h41;
    localparam logic [CHAR_W-1:0] CH_C     = 7'h43;
    localparam logic [CHAR_W-1:0] CH_D     = 7'h44;
    localparam logic [CHAR_W-1:0] CH_E     = 7'h45;
    localparam logic [CHAR_W-1:0] CH_I     = 7'h49;
    localparam logic [CHAR_W-1:0] CH_N     = 7'h4E;
    localparam logic [CHAR_W-1:0] CH_O     = 7'h4F;
    localparam logic [CHAR_W-1:0] CH_U     = 7'h55;
    localparam logic [CHAR_W-1:0] CH_Y     = 7'h59;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              last_byte;
    } t_in_item;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              end_of_string;
    } t_out_item;

    typedef enum logic [1:0] {
        SYM_NONE     = 2'd0,
        SYM_SPACE    = 2'd1,
        SYM_CHAR     = 2'd2,
        SYM_ELLIPSIS = 2'd3
    } t_sym_kind;

    typedef struct packed {
        t_sym_kind         kind;
        logic [CHAR_W-1:0] ch;
    } t_sym;

    // Number of continuation bytes a lead byte asks for; zero for any other byte.
    function automatic logic [1:0] f_seq_need(input logic [BYTE_W-1:0] b);
        logic [1:0] need;
        need = 2'd0;
        if (b[7:5] == 3'b110) begin
            need = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
            need = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
            need = 2'd3;
        end
        return need;
    endfunction

    // Upper-case letter pair with lower case chosen by one bit.
    function automatic logic [CHAR_W-1:0] f_letter(input logic [CHAR_W-1:0] up,
                                                   input logic lower);
        return up | {1'b0, lower, 5'd0};
    endfunction

    // Base letter of the Latin-1 block 0xC0..0xDF; zero where nothing is shown.
    function automatic logic [CHAR_W-1:0] f_latin1_upper(input logic [4:0] idx);
        logic [CHAR_W-1:0] up;
        unique case (idx) inside
            [5'd0:5'd5]:   up = CH_A;
            5'd7:          up = CH_C;
            [5'd8:5'd11]:  up = CH_E;
            [5'd12:5'd15]: up = CH_I;
            5'd16:         up = CH_D;
            5'd17:         up = CH_N;
            [5'd18:5'd22]: up = CH_O;
            5'd24:         up = CH_O;
            [5'd25:5'd28]: up = CH_U;
            5'd29:         up = CH_Y;
            default:       up = CH_NUL;
        endcase
        return up;
    endfunction

    // What one codepoint turns into.
    function automatic t_sym f_classify(input logic [CP_W-1:0] cp);
        t_sym              s;
        logic [CHAR_W-1:0] up;
        logic [CHAR_W-1:0] c;
        s.kind = SYM_NONE;
        s.ch   = CH_NUL;
        c      = cp[CHAR_W-1:0];
        up     = CH_NUL;
        if (cp < 21'h80) begin
            if (c == CH_CR || c == CH_LF || c == CH_TAB || c == CH_SPACE) begin
                s.kind = SYM_SPACE;
                s.ch   = CH_SPACE;
            end else if (c > CH_SPACE && c != CH_DEL) begin
                s.kind = SYM_CHAR;
                s.ch   = c;
            end
        end else if (cp == 21'h2026) begin
            s.kind = SYM_ELLIPSIS;
            s.ch   = CH_DOT;
        end else if (cp >= 21'hC0 && cp <= 21'hFE) begin
            up = f_latin1_upper(cp[4:0]);
            if (up != CH_NUL) begin
                s.kind = SYM_CHAR;
                s.ch   = f_letter(up, cp[5]);
            end
        end else begin
            s.kind = SYM_CHAR;
            case (cp) inside
                21'h0000A0: begin
                    s.kind = SYM_SPACE;
                    s.ch   = CH_SPACE;
                end
                21'h0000FF:                       s.ch = f_letter(CH_Y, 1'b1);
                [21'h002018:21'h00201B]:          s.ch = CH_APOS;
                [21'h00201C:21'h00201F]:          s.ch = CH_QUOTE;
                21'h002013, 21'h002014, 21'h002212: s.ch = CH_DASH;
                21'h000102:                       s.ch = CH_A;
                21'h000103:                       s.ch = f_letter(CH_A, 1'b1);
                21'h000110:                       s.ch = CH_D;
                21'h000111:                       s.ch = f_letter(CH_D, 1'b1);
                21'h0001A0:                       s.ch = CH_O;
                21'h0001A1:                       s.ch = f_letter(CH_O, 1'b1);
                21'h0001AF:                       s.ch = CH_U;
                21'h0001B0:                       s.ch = f_letter(CH_U, 1'b1);
                21'h000178:                       s.ch = CH_Y;
                [21'h001EA0:21'h001EB7]:          s.ch = f_letter(CH_A, cp[0]);
                [21'h001EB8:21'h001EC7]:          s.ch = f_letter(CH_E, cp[0]);
                [21'h001EC8:21'h001ECB]:          s.ch = f_letter(CH_I, cp[0]);
                [21'h001ECC:21'h001EE3]:          s.ch = f_letter(CH_O, cp[0]);
                [21'h001EE4:21'h001EF1]:          s.ch = f_letter(CH_U, cp[0]);
                [21'h001EF2:21'h001EF9]:          s.ch = f_letter(CH_Y, cp[0]);
                default: begin
                    s.kind = SYM_NONE;
                    s.ch   = CH_NUL;
                end
            endcase
        end
        return s;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/utf8_text_sanitizer.sv
`default_nettype none
// An accepted byte is held in the input register, then its results load the result register.
// Throughput: one byte per cycle while each byte yields at most one result and the output
// is ready; a byte that yields n results (n up to four) holds the input until its last result
// is taken, while the result register drains one transaction per cycle when the output is ready.
// Reset (synchronous, active low): capacity returns to 127; string state but r_pend_cont clears.
module utf8_text_sanitizer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  uts_pkg::t_in_item                i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output uts_pkg::t_out_item               o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [uts_pkg::CFG_W-1:0]        i_cfg_max_chars
);
    import uts_pkg::*;

    // Configuration.
    logic [CFG_W-1:0]     r_max_chars;

    // Input register.
    logic                 r_in_valid;
    t_in_item             r_in_item;

    // String state.
    logic [BYTE_W-1:0]    r_pend_lead, n_pend_lead;
    logic [1:0]           r_pend_cnt, n_pend_cnt;
    logic [BYTE_W-1:0]    r_pend_cont [2];
    logic [BYTE_W-1:0]    n_pend_cont [2];
    logic                 r_prev_space, n_prev_space;
    logic [CFG_W-1:0]     r_chars_written, n_chars_written;

    // Result register: the up to four characters of one byte, drained in order.
    logic [CHAR_W-1:0]    r_res_char [RES_MAX];
    logic                 r_res_end;
    logic [RES_CNT_W-1:0] r_res_left;
    logic [RES_IDX_W-1:0] r_res_idx;

    // Processing logic.
    logic [BYTE_W-1:0]    cur_byte;
    logic                 cur_last;
    logic                 end_str;
    logic                 byte_cont;
    logic [1:0]           lead_need;
    logic [1:0]           fresh_need;
    logic [EV_NUM-1:0]    ev_vld;
    logic [CP_W-1:0]      ev_cp [EV_NUM];
    t_sym                 ev_sym [EV_NUM];
    logic [CHAR_W-1:0]    want_ch [RES_MAX];
    logic [RES_CNT_W-1:0] want_n;
    logic                 want_space;
    logic [CFG_W-1:0]     room;
    logic [RES_CNT_W-1:0] limit;
    logic [RES_CNT_W-1:0] take_n;
    logic [RES_CNT_W-1:0] res_n;
    logic [CHAR_W-1:0]    res_ch [RES_MAX];
    logic                 res_free;
    logic                 proc;
    logic                 out_take;

    assign cur_byte  = r_in_item.in_byte;
    assign cur_last  = r_in_item.last_byte;
    assign end_str   = (cur_byte == '0) || cur_last;
    assign byte_cont = (cur_byte[7:6] == 2'b10);
    assign lead_need = f_seq_need(r_pend_lead);
    assign fresh_need = f_seq_need(cur_byte);

    // The result register can take a new byte's results once its last pending
    // transaction completes, so a new byte is processed in the same cycle as that transaction.
    assign out_take   = o_out_valid && i_out_ready;
    assign res_free   = (r_res_left == '0) || ((r_res_left == 3'd1) && i_out_ready);
    assign proc       = r_in_valid && res_free;
    assign o_in_ready = !r_in_valid || proc;
    assign o_cfg_ready = 1'b1;

    // Decode the byte against the pending sequence into at most four codepoint
    // events, in emission order: the old lead byte, up to two continuation
    // bytes, and finally whatever the current byte yields.
    always_comb begin
        ev_vld      = '0;
        for (int e = 0; e < EV_NUM; e++) begin
            ev_cp[e] = '0;
        end
        n_pend_lead = r_pend_lead;
        n_pend_cnt  = r_pend_cnt;
        n_pend_cont = r_pend_cont;

        if (cur_byte == '0) begin
            // A terminator flushes whatever is pending as a broken sequence.
            if (r_pend_lead != '0) begin
                ev_vld[0] = 1'b1;
                ev_cp[0]  = CP_W'(r_pend_lead);
                ev_vld[1] = (r_pend_cnt >= 2'd1);
                ev_cp[1]  = CP_W'(r_pend_cont[0]);
                ev_vld[2] = (r_pend_cnt >= 2'd2);
                ev_cp[2]  = CP_W'(r_pend_cont[1]);
            end
        end else if (r_pend_lead != '0 && byte_cont) begin
            if (({1'b0, r_pend_cnt} + 3'd1) < {1'b0, lead_need}) begin
                // Sequence still short: buffer the continuation byte, or flush it all on the last flag.
                n_pend_cont[r_pend_cnt[0]] = cur_byte;
                n_pend_cnt = r_pend_cnt + 2'd1;
                if (cur_last) begin
                    ev_vld[0] = 1'b1;
                    ev_cp[0]  = CP_W'(r_pend_lead);
                    ev_vld[1] = 1'b1;
                    ev_cp[1]  = (r_pend_cnt == 2'd0) ? CP_W'(cur_byte)
                                                     : CP_W'(r_pend_cont[0]);
                    ev_vld[2] = (r_pend_cnt == 2'd1);
                    ev_cp[2]  = CP_W'(cur_byte);
                end
            end else begin
                // Sequence complete: assemble the codepoint.
                ev_vld[3] = 1'b1;
                unique case (lead_need)
                    2'd1: ev_cp[3] = CP_W'({r_pend_lead[4:0], cur_byte[5:0]});
                    2'd2: ev_cp[3] = CP_W'({r_pend_lead[3:0], r_pend_cont[0][5:0],
                                            cur_byte[5:0]});
                    default: ev_cp[3] = {r_pend_lead[2:0], r_pend_cont[0][5:0],
                                         r_pend_cont[1][5:0], cur_byte[5:0]};
                endcase
                n_pend_lead = '0;
                n_pend_cnt  = '0;
            end
        end else begin
            // No sequence, or one broken by a byte that is not a continuation.
            if (r_pend_lead != '0) begin
                ev_vld[0] = 1'b1;
                ev_cp[0]  = CP_W'(r_pend_lead);
                ev_vld[1] = (r_pend_cnt >= 2'd1);
                ev_cp[1]  = CP_W'(r_pend_cont[0]);
                ev_vld[2] = (r_pend_cnt >= 2'd2);
                ev_cp[2]  = CP_W'(r_pend_cont[1]);
            end
            n_pend_lead = '0;
            n_pend_cnt  = '0;
            // A single byte, or a new lead byte flushed at once by the last flag,
            // counts as the codepoint of its own value.
            if (fresh_need == 2'd0 || cur_last) begin
                ev_vld[3] = 1'b1;
                ev_cp[3]  = CP_W'(cur_byte);
            end else begin
                n_pend_lead = cur_byte;
            end
        end

        if (end_str) begin
            n_pend_lead = '0;
            n_pend_cnt  = '0;
        end
    end

    always_comb begin
        for (int e = 0; e < EV_NUM; e++) begin
            ev_sym[e] = f_classify(ev_cp[e]);
        end
    end

    // Build the characters the events ask for, collapsing runs of spaces. Only
    // the first four can ever leave in one step, so the list saturates there.
    always_comb begin
        want_n     = '0;
        want_space = r_prev_space;
        for (int k = 0; k < RES_MAX; k++) begin
            want_ch[k] = CH_NUL;
        end
        for (int e = 0; e < EV_NUM; e++) begin
            if (ev_vld[e]) begin
                case (ev_sym[e].kind)
                    SYM_SPACE: begin
                        if (!want_space) begin
                            want_space = 1'b1;
                            if (want_n < RES_CNT_W'(RES_MAX)) begin
                                want_ch[want_n[RES_IDX_W-1:0]] = CH_SPACE;
                                want_n = want_n + 3'd1;
                            end
                        end
                    end
                    SYM_CHAR: begin
                        want_space = 1'b0;
                        if (want_n < RES_CNT_W'(RES_MAX)) begin
                            want_ch[want_n[RES_IDX_W-1:0]] = ev_sym[e].ch;
                            want_n = want_n + 3'd1;
                        end
                    end
                    SYM_ELLIPSIS: begin
                        want_space = 1'b0;
                        for (int j = 0; j < 3; j++) begin
                            if (want_n < RES_CNT_W'(RES_MAX)) begin
                                want_ch[want_n[RES_IDX_W-1:0]] = CH_DOT;
                                want_n = want_n + 3'd1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Capacity: once the string holds max_chars characters, the rest are
    // dropped, so only a prefix of the wanted characters is kept.
    always_comb begin
        room  = '0;
        limit = '0;
        if (r_max_chars > r_chars_written) begin
            room  = r_max_chars - r_chars_written;
            limit = (room >= CFG_W'(RES_MAX)) ? RES_CNT_W'(RES_MAX) : room[RES_CNT_W-1:0];
        end
        take_n = (want_n < limit) ? want_n : limit;

        res_ch = want_ch;
        res_n  = take_n;
        // With nothing to show at the end of a string, a lone terminator result.
        if (end_str && take_n == '0) begin
            res_n     = 3'd1;
            res_ch[0] = CH_NUL;
        end

        n_chars_written = end_str ? '0 : (r_chars_written + CFG_W'(take_n));
        n_prev_space    = end_str ? 1'b0 : want_space;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_chars     <= MAX_CHARS_RESET;
            r_in_valid      <= 1'b0;
            r_pend_lead     <= '0;
            r_pend_cnt      <= '0;
            r_prev_space    <= 1'b0;
            r_chars_written <= '0;
            r_res_left      <= '0;
            r_res_idx       <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_chars <= i_cfg_max_chars;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (proc) begin
                r_pend_lead     <= n_pend_lead;
                r_pend_cnt      <= n_pend_cnt;
                r_prev_space    <= n_prev_space;
                r_chars_written <= n_chars_written;
                r_res_left      <= res_n;
                r_res_idx       <= '0;
            end else if (out_take) begin
                r_res_left <= r_res_left - 3'd1;
                r_res_idx  <= r_res_idx + 2'd1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_data;
        end
        if (proc) begin
            r_pend_cont <= n_pend_cont;
            r_res_char  <= res_ch;
            r_res_end   <= end_str;
        end
    end

    // The end marker rides on the last transaction of the final byte.
    assign o_out_valid              = (r_res_left != '0);
    assign o_out_data.out_char      = r_res_char[r_res_idx];
    assign o_out_data.end_of_string = r_res_end && (r_res_left == 3'd1);

endmodule
`default_nettype wire
